// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// depends on nothing; users provide clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check, disabled while in reset
`define CHK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");

// check that must also hold during reset
`define CHK_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");

`endif

// ----- hdl/rpdp_pkg.sv -----
// types and constants for the row pair dot product block
// used by every module of the block
package rpdp_pkg;

  localparam int MAX_A_ROWS = 8;
  localparam int MAX_B_ROWS = 8;
  localparam int MAX_COLS   = 64;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 6;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;
  localparam int DRAIN_CYC  = MAX_B_ROWS + 4;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_LOAD_BIAS = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_B_ROWS = 2'd1,
    REG_COLS = 2'd2,
    REG_BIAS_MODE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    BIAS_NONE = 2'd0,
    BIAS_A_ROW = 2'd1,
    BIAS_B_ROW = 2'd2,
    BIAS_UNUSED = 2'd3
  } bias_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FEED,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic [ROW_W-1:0]        out_col;
    logic signed [ACC_W-1:0] out_value;
    logic                    last;
  } out_t;

  // element handed from cell to cell
  typedef struct packed {
    logic                    v;
    logic [COL_W-1:0]        k;
    logic signed [VAL_W-1:0] a;
  } link_t;

  typedef struct packed {
    logic                    en;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
  } wr_t;

  typedef struct packed {
    logic clr;
    logic cap;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- hdl/rpdp_cell.sv -----
// one cell of the chain: holds one B row, accumulates its dot product
// depends on rpdp_pkg
module rpdp_cell import rpdp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wr_t                     wr,
  input  cell_ctl_t               ctl,
  input  link_t                   link_i,
  output link_t                   link_o,
  input  logic signed [ACC_W-1:0] res_i,
  output logic signed [ACC_W-1:0] res_o
);

  logic signed [VAL_W-1:0]  b_mem [MAX_COLS];
  logic signed [VAL_W-1:0]  b_rd_r;
  logic signed [VAL_W-1:0]  a_d_r;
  logic                     v1_r, v2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, res_r;
  link_t                    link_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      b_mem[wr.col] <= wr.val;
    end
    b_rd_r <= b_mem[link_i.k];
    a_d_r  <= link_i.a;
    prod_r <= a_d_r * b_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      link_r <= '0;
    end else begin
      v1_r   <= link_i.v;
      v2_r   <= v1_r;
      link_r <= link_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.cap) begin
      res_r <= acc_r;
    end else if (ctl.shift) begin
      res_r <= res_i;
    end
  end

  assign link_o = link_r;
  assign res_o  = res_r;

endmodule

// ----- hdl/row_pair_dot_products_with_bias.sv -----
// top level: command sequencer, A and bias stores, chain of B row cells
// depends on rpdp_pkg and rpdp_cell
//
// channel  ports                       direction  handshake
// input    start, busy, in_data        in         start && !busy
// config   cfg_valid, cfg_ready, ...   in         cfg_valid && cfg_ready
// result   out_strobe, out_data        out        out_strobe, one cycle
//
// loads are written into the stores when accepted; compute walks one A row at a time
// per A row: clear, feed cols_used elements into the cell chain, drain them through
// the cells and multiplier stages, then shift out b_rows_used results
// results leave one per cycle from the head of the cell chain, cannot be stalled
// synchronous reset sets registers to their reset values; stores are not cleared
module row_pair_dot_products_with_bias import rpdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  output logic       out_strobe,
  output out_t       out_data
);

  state_t state_r, state_nxt;
  logic [3:0] a_rows_r, b_rows_r;
  logic [6:0] cols_r;
  logic [1:0] bias_mode_r;
  logic [3:0] na, nb;
  logic [6:0] nc;
  logic [ROW_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [6:0] k_r, k_nxt;
  logic [3:0] dcnt_r, dcnt_nxt;
  logic accept;

  logic signed [VAL_W-1:0] a_mem [MAX_A_ROWS*MAX_COLS];
  logic signed [VAL_W-1:0] a_rd_r;
  logic signed [VAL_W-1:0] bias_r [MAX_A_ROWS];
  logic feed_v_r;
  logic [COL_W-1:0] feed_k_r;

  link_t links [MAX_B_ROWS+1];
  logic signed [ACC_W-1:0] res [MAX_B_ROWS+1];
  cell_ctl_t ctl;
  out_t out_nxt, out_r;
  logic out_strobe_r;
  logic signed [VAL_W-1:0] bias_sel;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign na = (a_rows_r > 4'(MAX_A_ROWS)) ? 4'(MAX_A_ROWS) : a_rows_r;
  assign nb = (b_rows_r > 4'(MAX_B_ROWS)) ? 4'(MAX_B_ROWS) : b_rows_r;
  assign nc = (cols_r > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r    <= 4'd8;
      b_rows_r    <= 4'd8;
      cols_r      <= 7'd64;
      bias_mode_r <= BIAS_NONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_A_ROWS:    a_rows_r    <= cfg_data[3:0];
        REG_B_ROWS:    b_rows_r    <= cfg_data[3:0];
        REG_COLS:      cols_r      <= cfg_data;
        REG_BIAS_MODE: bias_mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // A store and bias store
  always_ff @(posedge clk) begin
    if (accept && in_data.command == CMD_LOAD_A) begin
      a_mem[{in_data.row, in_data.col}] <= in_data.value;
    end
    a_rd_r <= a_mem[{i_r, k_r[COL_W-1:0]}];
    if (accept && in_data.command == CMD_LOAD_BIAS) begin
      bias_r[in_data.row] <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      dcnt_r       <= '0;
      feed_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      dcnt_r       <= dcnt_nxt;
      feed_v_r     <= (state_r == ST_FEED);
      out_strobe_r <= (state_r == ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    feed_k_r <= k_r[COL_W-1:0];
    out_r    <= out_nxt;
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    dcnt_nxt  = dcnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_data.command == CMD_COMPUTE && na != 4'd0 && nb != 4'd0) begin
          state_nxt = ST_CLEAR;
          i_nxt     = '0;
        end
      end
      ST_CLEAR: begin
        k_nxt    = '0;
        dcnt_nxt = '0;
        j_nxt    = '0;
        state_nxt = (nc == 7'd0) ? ST_DRAIN : ST_FEED;
      end
      ST_FEED: begin
        k_nxt = k_r + 7'd1;
        if (k_r + 7'd1 == nc) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'(DRAIN_CYC - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        j_nxt = j_r + 3'd1;
        if ({1'b0, j_r} + 4'd1 == nb) begin
          if ({1'b0, i_r} + 4'd1 == na) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 3'd1;
            state_nxt = ST_CLEAR;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (bias_mode_t'(bias_mode_r))
      BIAS_A_ROW: bias_sel = bias_r[i_r];
      BIAS_B_ROW: bias_sel = bias_r[j_r];
      default:    bias_sel = '0;
    endcase
  end

  // outputs
  always_comb begin
    ctl.clr   = (state_r == ST_CLEAR);
    ctl.cap   = (state_r == ST_DRAIN) && (dcnt_r == 4'(DRAIN_CYC - 1));
    ctl.shift = (state_r == ST_OUT);
    out_nxt.out_row   = i_r;
    out_nxt.out_col   = j_r;
    out_nxt.out_value = res[0] + {{(ACC_W-VAL_W-8){bias_sel[VAL_W-1]}}, bias_sel, 8'b0};
    out_nxt.last      = ({1'b0, j_r} + 4'd1 == nb) && ({1'b0, i_r} + 4'd1 == na);
  end

  assign links[0] = '{v: feed_v_r, k: feed_k_r, a: a_rd_r};
  assign res[MAX_B_ROWS] = '0;

  for (genvar g = 0; g < MAX_B_ROWS; g++) begin : g_cell
    wr_t wr;
    assign wr.en  = accept && (in_data.command == CMD_LOAD_B) &&
                    (in_data.row == ROW_W'(g));
    assign wr.col = in_data.col;
    assign wr.val = in_data.value;
    rpdp_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr     (wr),
      .ctl    (ctl),
      .link_i (links[g]),
      .link_o (links[g+1]),
      .res_i  (res[g+1]),
      .res_o  (res[g])
    );
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// ----- hdl/rpdp_checker.sv -----
// port level checks for the row pair dot product block, bound to the top
// depends on rpdp_pkg and assert_macros.svh
`include "assert_macros.svh"

module rpdp_checker import rpdp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_strobe,
  input out_t out_data
);

  // nothing follows the final word of a run in the next cycle
  `CHK_ASSERT(p_last_ends, out_strobe && out_data.last |=> !out_strobe)
  // loads never make the block busy
  `CHK_ASSERT(p_load_idle, start && !busy && in_data.command != CMD_COMPUTE |=> !busy)
  // a word only comes out of a running compute
  `CHK_ASSERT(p_word_busy, out_strobe |-> $past(busy))
  // a word that is not final leaves the block still busy
  `CHK_ASSERT(p_more_busy, out_strobe && !out_data.last |-> busy)

endmodule

bind row_pair_dot_products_with_bias rpdp_checker u_rpdp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
